@@ hdl/fhc_pkg.sv @@
// Shared types and constants for the frame header checker.
package fhc_pkg;

    localparam int HDR_BYTES = 12;
    localparam int HDR_POS_W = $clog2(HDR_BYTES + 1);
    localparam int CNT_W     = 32;

    // Header byte positions
    localparam logic [HDR_POS_W-1:0] POS_MAGIC0  = HDR_POS_W'(0);
    localparam logic [HDR_POS_W-1:0] POS_MAGIC1  = HDR_POS_W'(1);
    localparam logic [HDR_POS_W-1:0] POS_VERSION = HDR_POS_W'(2);
    localparam logic [HDR_POS_W-1:0] POS_TYPE    = HDR_POS_W'(3);
    localparam logic [HDR_POS_W-1:0] POS_SEQ     = HDR_POS_W'(4);
    localparam logic [HDR_POS_W-1:0] POS_LEN     = HDR_POS_W'(8);
    localparam logic [HDR_POS_W-1:0] POS_DONE    = HDR_POS_W'(HDR_BYTES);

    // Payload byte count at which the total byte count reaches 2^32-1
    localparam logic [CNT_W-1:0] TAIL_MAX = {CNT_W{1'b1}} - CNT_W'(HDR_BYTES);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_LENGTH  = 3'd4,
        ST_TOO_BIG = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAGIC_FIRST  = 2'd0,
        CFG_MAGIC_SECOND = 2'd1,
        CFG_VERSION      = 2'd2,
        CFG_CAPACITY     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]       magic_first;
        logic [7:0]       magic_second;
        logic [7:0]       expected_version;
        logic [CNT_W-1:0] payload_capacity;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       message_type;
        logic [CNT_W-1:0] sequence_number;
        logic [CNT_W-1:0] payload_length;
    } result_t;

endpackage

@@ hdl/fhc_in_reg.sv @@
// Input register stage: holds one accepted byte transaction for the tracker.
module fhc_in_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tuser,   // [0] has_byte
    input  logic           s_tlast,
    output fhc_pkg::item_t item,
    output logic           item_valid,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    fhc_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || item_take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte     <= s_tdata;
            item_reg.has_byte      <= s_tuser;
            item_reg.end_of_buffer <= s_tlast;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ hdl/fhc_hdr_track.sv @@
// Header tracker: byte position, header capture, payload count and final checks.
module fhc_hdr_track
(
    input  logic             clk,
    input  logic             rst_n,
    input  fhc_pkg::cfg_t    cfg,
    input  fhc_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_take,
    input  logic             out_free,
    output logic             res_valid,
    output fhc_pkg::result_t res
);

    logic [fhc_pkg::HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [fhc_pkg::CNT_W-1:0]     tail_reg, tail_next;
    logic                          magic_reg, magic_next;
    logic                          version_reg, version_next;
    logic [7:0]                    type_reg, type_next;
    logic [fhc_pkg::CNT_W-1:0]     seq_reg, seq_next;
    logic [fhc_pkg::CNT_W-1:0]     len_reg, len_next;

    logic saturated;
    logic take_byte;
    logic in_header;

    // a final item waits until the result register can take its result
    assign item_take = item_valid && (!item.end_of_buffer || out_free);
    assign res_valid = item_take && item.end_of_buffer;

    assign saturated = (tail_reg == fhc_pkg::TAIL_MAX);
    assign take_byte = item.has_byte && !saturated;
    assign in_header = (hdr_pos_reg != fhc_pkg::POS_DONE);

    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        tail_next    = tail_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;

        if (take_byte)
        begin
            if (!in_header)
            begin
                tail_next = tail_reg + fhc_pkg::CNT_W'(1);
            end
            else
            begin
                hdr_pos_next = hdr_pos_reg + fhc_pkg::HDR_POS_W'(1);
                if (hdr_pos_reg == fhc_pkg::POS_MAGIC0)
                begin
                    magic_next = magic_reg && (item.data_byte == cfg.magic_first);
                end
                else if (hdr_pos_reg == fhc_pkg::POS_MAGIC1)
                begin
                    magic_next = magic_reg && (item.data_byte == cfg.magic_second);
                end
                else if (hdr_pos_reg == fhc_pkg::POS_VERSION)
                begin
                    version_next = version_reg && (item.data_byte == cfg.expected_version);
                end
                else if (hdr_pos_reg == fhc_pkg::POS_TYPE)
                begin
                    type_next = item.data_byte;
                end
                else if (hdr_pos_reg < fhc_pkg::POS_LEN)
                begin
                    seq_next = {seq_reg[fhc_pkg::CNT_W-9:0], item.data_byte};
                end
                else
                begin
                    len_next = {len_reg[fhc_pkg::CNT_W-9:0], item.data_byte};
                end
            end
        end
    end

    // Checks in priority order, on the state including this item's byte
    always_comb
    begin
        res = '0;
        if (hdr_pos_next != fhc_pkg::POS_DONE)
        begin
            res.status = fhc_pkg::ST_SHORT;
        end
        else if (!magic_next)
        begin
            res.status = fhc_pkg::ST_MAGIC;
        end
        else if (!version_next)
        begin
            res.status = fhc_pkg::ST_VERSION;
        end
        else if (len_next > tail_next)
        begin
            res.status = fhc_pkg::ST_LENGTH;
        end
        else if (len_next > cfg.payload_capacity)
        begin
            res.status = fhc_pkg::ST_TOO_BIG;
        end
        else
        begin
            res.status          = fhc_pkg::ST_OK;
            res.message_type    = type_next;
            res.sequence_number = seq_next;
            res.payload_length  = len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg <= '0;
            tail_reg    <= '0;
            magic_reg   <= 1'b1;
            version_reg <= 1'b1;
            type_reg    <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
        end
        else if (item_take)
        begin
            if (item.end_of_buffer)
            begin
                hdr_pos_reg <= '0;
                tail_reg    <= '0;
                magic_reg   <= 1'b1;
                version_reg <= 1'b1;
                type_reg    <= '0;
                seq_reg     <= '0;
                len_reg     <= '0;
            end
            else
            begin
                hdr_pos_reg <= hdr_pos_next;
                tail_reg    <= tail_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                type_reg    <= type_next;
                seq_reg     <= seq_next;
                len_reg     <= len_next;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (hdr_pos_reg == '0) && (tail_reg == '0) && magic_reg && version_reg)
        else $error("state not cleared after end of buffer");

    a_tail_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != '0) |-> (hdr_pos_reg == fhc_pkg::POS_DONE))
        else $error("payload counted before header complete");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= fhc_pkg::POS_DONE)
        else $error("header position overran");

    a_magic_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!magic_reg && !res_valid) |=> !magic_reg)
        else $error("magic mismatch lost within a buffer");

endmodule

@@ hdl/fhc_out_reg.sv @@
// Result register: holds one result transaction until the sink takes it.
module fhc_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  fhc_pkg::result_t res,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // [7:0] message_type, [39:8] sequence_number,
                                        // [71:40] payload_length
    output logic [2:0]       m_tuser    // [2:0] status
);

    logic             valid_reg;
    logic             valid_next;
    fhc_pkg::result_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = res_valid || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.payload_length, res_reg.sequence_number, res_reg.message_type};
    assign m_tuser  = res_reg.status;

endmodule

@@ hdl/frame_header_checker.sv @@
// Top level of the frame header checker: config registers and stage wiring.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[7:0] data_byte, tuser has_byte, tlast end_of_buffer
// m_*       out  tvalid/tready      tdata message_type/sequence_number/payload_length,
//                                   tuser status
// cfg_*     in   cfg_wr_en          cfg_index register, cfg_wr_data value
//
// One byte transaction per cycle sustained while no final transaction waits on a
// stalled result register; m_tvalid rises once the final transaction of a buffer
// has passed the input register, then the result register.
// The throughput is set by the tracker's state update.
// Reset is asynchronous and active low; it clears the config registers, the
// header state and both valid flags. No clearing pass is needed.
// A stalled result register holds back only a final transaction; ordinary
// bytes keep flowing while a result waits.
module frame_header_checker
(
    input  logic        clk,
    input  logic        rst_n,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] has_byte
    input  logic        s_tlast,
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [7:0] message_type, [39:8] sequence_number,
                                    // [71:40] payload_length
    output logic [2:0]  m_tuser,    // [2:0] status
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    fhc_pkg::cfg_t    cfg_reg;
    fhc_pkg::item_t   item;
    fhc_pkg::result_t res;
    logic             item_valid;
    logic             item_take;
    logic             out_free;
    logic             res_valid;

    // Config registers; the user must write them only while idle, with no guard in the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (fhc_pkg::cfg_idx_t'(cfg_index))
                fhc_pkg::CFG_MAGIC_FIRST:  cfg_reg.magic_first      <= cfg_wr_data[7:0];
                fhc_pkg::CFG_MAGIC_SECOND: cfg_reg.magic_second     <= cfg_wr_data[7:0];
                fhc_pkg::CFG_VERSION:      cfg_reg.expected_version <= cfg_wr_data[7:0];
                fhc_pkg::CFG_CAPACITY:     cfg_reg.payload_capacity <= cfg_wr_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stage 1: input register
    fhc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Header state and end-of-buffer checks
    fhc_hdr_track u_hdr_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Stage 2: result register
    fhc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ tb/sv/tb_frame_header_checker.sv @@
// Self-checking testbench for the frame header checker: directed table, then random buffers.
`timescale 1ns / 1ps

module tb_frame_header_checker;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on any port
    localparam int DRAIN_CYCLES   = 8;     // settle time after every verdict is back
    localparam int PHASES         = 7;     // register settings in the random part
    localparam int PHASE_ITEMS    = 145;   // byte/end transactions per setting
    localparam logic [31:0] HDR_LEN = 32'(fhc_pkg::HDR_BYTES);

    // Directed rows: a typed result is used only where it is obvious by eye.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             has_byte;
        logic             end_mark;
        logic             typed;
        fhc_pkg::result_t want;
    } directed_row_t;

    localparam fhc_pkg::result_t NONE        = '0;
    localparam fhc_pkg::result_t SHORT_ZERO  = '{fhc_pkg::ST_SHORT, 8'h00, 32'h0, 32'h0};
    localparam fhc_pkg::result_t OK_EXTREME  = '{fhc_pkg::ST_OK, 8'hFF, 32'hFFFF_FFFF, 32'h0};
    localparam fhc_pkg::result_t LENGTH_ZERO = '{fhc_pkg::ST_LENGTH, 8'h00, 32'h0, 32'h0};

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        // lone end marker right after reset: nothing counted, too short
        '{8'hFF, 1'b0, 1'b1, 1'b1, SHORT_ZERO},
        // all-zero magic/version matches reset registers; type and sequence all ones,
        // length zero fits an empty payload and zero capacity
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b1, 1'b1, OK_EXTREME},
        // maximum length with no payload behind it
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b1, 1'b1, LENGTH_ZERO}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'h00;   // [7:0] data_byte
    logic                s_tuser     = 1'b0;    // [0] has_byte
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [71:0]         m_tdata;               // [7:0] message_type, [39:8] sequence_number,
                                                // [71:40] payload_length
    logic [2:0]          m_tuser;               // [2:0] status
    logic                cfg_wr_en   = 1'b0;
    fhc_pkg::cfg_idx_t   cfg_index   = fhc_pkg::CFG_MAGIC_FIRST;
    logic [31:0]         cfg_wr_data = 32'h0;

    frame_header_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Header predictor: own copy of the registers and the parse state
    // ---------------------------------------------------------------
    logic [7:0]  want_magic0  = 8'h00;
    logic [7:0]  want_magic1  = 8'h00;
    logic [7:0]  want_version = 8'h00;
    logic [31:0] capacity     = 32'h0;

    logic [31:0] seen_bytes   = 32'h0;
    logic        magic_ok     = 1'b1;
    logic        version_ok   = 1'b1;
    logic [7:0]  held_type    = 8'h00;
    logic [31:0] held_seq     = 32'h0;
    logic [31:0] held_len     = 32'h0;

    fhc_pkg::result_t header_results_due [$];   // oldest expected header verdict first

    int  mismatches   = 0;
    int  items_sent   = 0;             // transactions carrying a byte or an end mark
    int  settings_run = 0;
    int  status_seen [6];
    bit  calm         = 1'b0;          // no idling on either side

    // One accepted byte transaction; returns a verdict when the buffer ends.
    function automatic void judge_header_item(input logic [7:0] b, input logic has,
                                              input logic last, output logic done,
                                              output fhc_pkg::result_t verdict);
        done    = 1'b0;
        verdict = '0;
        // count saturates; bytes past saturation are neither captured nor compared
        if (has && seen_bytes != 32'hFFFF_FFFF)
        begin
            case (seen_bytes)
                32'd0:  if (b != want_magic0) magic_ok = 1'b0;
                32'd1:  if (b != want_magic1) magic_ok = 1'b0;
                32'd2:  if (b != want_version) version_ok = 1'b0;
                32'd3:  held_type = b;
                32'd4, 32'd5, 32'd6, 32'd7:
                        held_seq = {held_seq[23:0], b};
                32'd8, 32'd9, 32'd10, 32'd11:
                        held_len = {held_len[23:0], b};
                default: ;   // payload: counted only
            endcase
            seen_bytes = seen_bytes + 32'd1;
        end
        if (last)
        begin
            done = 1'b1;
            if (seen_bytes < HDR_LEN)
                verdict.status = fhc_pkg::ST_SHORT;
            else if (!magic_ok)
                verdict.status = fhc_pkg::ST_MAGIC;
            else if (!version_ok)
                verdict.status = fhc_pkg::ST_VERSION;
            else if (held_len > seen_bytes - HDR_LEN)
                verdict.status = fhc_pkg::ST_LENGTH;
            else if (held_len > capacity)
                verdict.status = fhc_pkg::ST_TOO_BIG;
            else
                verdict.status = fhc_pkg::ST_OK;
            if (verdict.status == fhc_pkg::ST_OK)
            begin
                verdict.message_type    = held_type;
                verdict.sequence_number = held_seq;
                verdict.payload_length  = held_len;
            end
            seen_bytes = 32'h0;
            magic_ok   = 1'b1;
            version_ok = 1'b1;
            held_type  = 8'h00;
            held_seq   = 32'h0;
            held_len   = 32'h0;
        end
    endfunction

    function automatic void apply_reg(input fhc_pkg::cfg_idx_t idx, input logic [31:0] value);
        case (idx)
            fhc_pkg::CFG_MAGIC_FIRST:  want_magic0  = value[7:0];
            fhc_pkg::CFG_MAGIC_SECOND: want_magic1  = value[7:0];
            fhc_pkg::CFG_VERSION:      want_version = value[7:0];
            fhc_pkg::CFG_CAPACITY:     capacity     = value;
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Byte stream driver
    // ---------------------------------------------------------------
    // Drives one transaction, waits for the handshake, then feeds the predictor.
    task automatic push_item(input logic [7:0] b, input logic has, input logic last,
                             input logic typed = 1'b0, input fhc_pkg::result_t want = '0);
        logic             done;
        fhc_pkg::result_t verdict;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (has || last)
            items_sent++;
        judge_header_item(b, has, last, done, verdict);
        if (done)
            header_results_due.push_back(typed ? want : verdict);
    endtask

    // Sender holds off until every verdict is back, then lets the pipe settle.
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (header_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; 8-bit ones get junk in the upper bits.
    task automatic program_regs(input logic [7:0] m0, input logic [7:0] m1,
                                input logic [7:0] ver, input logic [31:0] cap);
        logic [31:0] values [4];
        values[0] = {24'($urandom), m0};
        values[1] = {24'($urandom), m1};
        values[2] = {24'($urandom), ver};
        values[3] = cap;
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= fhc_pkg::cfg_idx_t'(i);
            cfg_wr_data <= values[i];
            @(posedge clk);
            apply_reg(fhc_pkg::cfg_idx_t'(i), values[i]);
        end
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    // One random buffer: mostly well-formed headers with random content, the rest
    // corrupted magic/version, short buffers and plain noise.
    task automatic send_buffer();
        logic [7:0]  frame [$];
        logic [31:0] seq;
        logic [31:0] len;
        int          kind;
        int          payload;
        int          spot;
        bit          marker_end;
        kind = $urandom_range(0, 99);
        seq  = $urandom;
        len  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 12);
        if (kind < 75)
        begin
            frame.push_back(want_magic0);
            frame.push_back(want_magic1);
            frame.push_back(want_version);
            frame.push_back(8'($urandom));
            for (int sh = 24; sh >= 0; sh -= 8)
                frame.push_back(seq[sh +: 8]);
            for (int sh = 24; sh >= 0; sh -= 8)
                frame.push_back(len[sh +: 8]);
            // payload near a small declared length, maybe one byte short; else 0 to 6 bytes
            if (len <= 32'd16)
            begin
                payload = int'(len) + $urandom_range(0, 3);
                if (len != 0 && $urandom_range(0, 4) == 0)
                    payload = int'(len) - 1;
            end
            else
                payload = $urandom_range(0, 6);
            repeat (payload) frame.push_back(8'($urandom));
            if (kind >= 63)
            begin
                spot = $urandom_range(0, 2);
                frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
            end
        end
        else if (kind < 88)
            repeat ($urandom_range(0, 11)) frame.push_back(8'($urandom));
        else
            repeat ($urandom_range(12, 24)) frame.push_back(8'($urandom));

        // end either on the last byte or with a separate end-only marker
        marker_end = (frame.size() == 0) || ($urandom_range(0, 3) == 0);
        foreach (frame[i])
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);   // empty transaction, ignored
            push_item(frame[i], 1'b1, !marker_end && (i == frame.size() - 1));
        end
        if (marker_end)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Result side: random backpressure and checking
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n || calm)
            m_tready <= rst_n;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        fhc_pkg::result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser < 3'd6)
                status_seen[m_tuser]++;
            if (header_results_due.size() == 0)
                flag_mismatch("result with none outstanding, status", 32'(m_tuser), 32'h0);
            else
            begin
                exp_res = header_results_due.pop_front();
                if (m_tuser != exp_res.status)
                    flag_mismatch("status", 32'(m_tuser), 32'(exp_res.status));
                if (m_tdata[7:0] != exp_res.message_type)
                    flag_mismatch("message_type", 32'(m_tdata[7:0]),
                                  32'(exp_res.message_type));
                if (m_tdata[39:8] != exp_res.sequence_number)
                    flag_mismatch("sequence_number", m_tdata[39:8],
                                  exp_res.sequence_number);
                if (m_tdata[71:40] != exp_res.payload_length)
                    flag_mismatch("payload_length", m_tdata[71:40],
                                  exp_res.payload_length);
            end
        end
    end

    // Watchdog: any transaction or register write counts as progress.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, header_results_due.size());
            $display("tb_frame_header_checker: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  ver;
        logic [31:0] cap;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run on the reset register values
        foreach (DIRECTED_ROWS[i])
            push_item(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].has_byte,
                      DIRECTED_ROWS[i].end_mark, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            int start_items;
            // registers change only with the pipe empty
            await_results();
            case (phase)
                0:
                begin
                    m0 = 8'hFF; m1 = 8'hFF; ver = 8'hFF; cap = 32'hFFFF_FFFF;
                end
                1:
                begin
                    m0 = 8'h00; m1 = 8'h00; ver = 8'h00; cap = 32'h0;
                end
                default:
                begin
                    m0  = 8'($urandom);
                    m1  = 8'($urandom);
                    ver = 8'($urandom);
                    cap = $urandom_range(0, 12);
                end
            endcase
            program_regs(m0, m1, ver, cap);
            calm = (phase == PHASES - 1);
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
            begin
                send_buffer();
                if (!calm && $urandom_range(0, 11) == 0)
                    await_results();
            end
        end

        await_results();

        $display("covered %0d byte/end transactions under %0d register settings",
                 items_sent, settings_run);
        $display("verdicts: ok %0d, short %0d, magic %0d, version %0d, length %0d, too big %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0)
            $display("tb_frame_header_checker: done, clean");
        else
            $display("tb_frame_header_checker: done, errors");
        $finish;
    end

endmodule
